>>> rtl/tbr_pkg.sv
// Shared types and constants for the tiled background pixel renderer.
// Holds the input and result word layouts, action codes and register indexes.
// No dependencies.
package tbr_pkg;

    // Default sizes of video memory and of the visible screen in tiles.
    localparam int VRAM_HALFWORDS_DEF    = 49152;
    localparam int SCREEN_TILES_WIDE_DEF = 30;
    localparam int SCREEN_TILES_HIGH_DEF = 20;

    // Video memory index arithmetic is done at this width, wide enough to hold the depth itself.
    localparam int VIDX_W = 17;

    // Palette geometry.
    localparam int PAL_ADDR_W  = 8;
    localparam int COLOR_W     = 15;

    // Configuration port geometry.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Register indexes, taken from the register select bit of paddr.
    localparam logic REG_MAP_BASE  = 1'b0;
    localparam logic REG_CHAR_BASE = 1'b1;

    // Input word actions.
    typedef enum logic [1:0] {
        ACT_VRAM_WRITE = 2'd0,
        ACT_PAL_WRITE  = 2'd1,
        ACT_RENDER     = 2'd2
    } action_t;

    // Input word.
    typedef struct packed {
        action_t     action;
        logic [15:0] address;
        logic [15:0] write_data;
        logic [7:0]  pixel_x;
        logic [7:0]  pixel_y;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] out_x;
        logic [7:0] out_y;
    } out_word_t;

    // Layer configuration as seen by the pipeline.
    typedef struct packed {
        logic [4:0] map_base;
        logic [1:0] char_base;
    } cfg_t;

endpackage

>>> rtl/tbr_cfg.sv
// Configuration registers of the tiled background renderer behind an APB-style port.
// Depends on tbr_pkg for the register indexes and the cfg_t struct.
module tbr_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tbr_pkg::PADDR_W-1:0]  paddr,
    input  logic [tbr_pkg::PDATA_W-1:0]  pwdata,
    output logic [tbr_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output tbr_pkg::cfg_t                cfg
);
    import tbr_pkg::*;

    logic [4:0] map_base_reg;
    logic [1:0] char_base_reg;
    logic       wr_strobe;

    // The port never inserts wait states.
    assign pready    = 1'b1;
    assign wr_strobe = psel & penable & pwrite & pready;

    // Register writes land in the access cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_base_reg  <= '0;
            char_base_reg <= '0;
        end else if (wr_strobe) begin
            case (paddr[2])
                REG_MAP_BASE:  map_base_reg  <= pwdata[4:0];
                REG_CHAR_BASE: char_base_reg <= pwdata[1:0];
                default: ;
            endcase
        end
    end

    // Read back the selected register.
    always_comb begin
        case (paddr[2])
            REG_MAP_BASE:  prdata = {27'd0, map_base_reg};
            REG_CHAR_BASE: prdata = {30'd0, char_base_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.map_base  = map_base_reg;
    assign cfg.char_base = char_base_reg;

endmodule

>>> rtl/tbr_vram.sv
// Video memory: one write port and two registered read ports, read-first on a collision.
// Depends on no package items beyond its own parameter.
module tbr_vram #(
    parameter int DEPTH = 49152
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [15:0]                wdata,
    input  logic                       re_a,
    input  logic [$clog2(DEPTH)-1:0]   raddr_a,
    output logic [15:0]                rdata_a,
    input  logic                       re_b,
    input  logic [$clog2(DEPTH)-1:0]   raddr_b,
    output logic [15:0]                rdata_b
);
    logic [15:0] mem [DEPTH];
    logic [15:0] rdata_a_reg;
    logic [15:0] rdata_b_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Map entry read port; the data holds until the next enabled read.
    always_ff @(posedge aclk) begin
        if (re_a) begin
            rdata_a_reg <= mem[raddr_a];
        end
    end

    // Tile pixel read port.
    always_ff @(posedge aclk) begin
        if (re_b) begin
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> rtl/tbr_palette.sv
// Palette memory: 256 colors of 15 bits with one write port and one registered read port.
// Depends on tbr_pkg for the palette geometry.
module tbr_palette (
    input  logic                              aclk,
    input  logic                              we,
    input  logic [tbr_pkg::PAL_ADDR_W-1:0]    waddr,
    input  logic [tbr_pkg::COLOR_W-1:0]       wdata,
    input  logic                              re,
    input  logic [tbr_pkg::PAL_ADDR_W-1:0]    raddr,
    output logic [tbr_pkg::COLOR_W-1:0]       rdata
);
    import tbr_pkg::*;

    logic [COLOR_W-1:0] mem [2**PAL_ADDR_W];
    logic [COLOR_W-1:0] rdata_reg;

    // Writes and reads come from the same pipeline stage, so they never overlap.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/tiled_background_pixel_renderer.sv
// Top level of the tiled background pixel renderer: three-stage memory pipeline.
// Depends on tbr_pkg, tbr_cfg, tbr_vram and tbr_palette.
//
// Usage:
//   The s_ channel takes one input word per cycle while s_ready is high. A video
//   write stores a halfword, a palette write stores a 15-bit color, and a render
//   word names a screen pixel. The m_ channel gives one result word (RGB888 and the
//   pixel position) for each on-screen render, in input order. Writes, off-screen
//   renders and the unused action give no result.
//   A render accepted on s_ moves through the stage 1, 2 and 3 registers in turn and
//   shows on m_valid from stage 3; receiver stalls can hold it back longer.
//   Throughput: one word per cycle unless stalled. Each render does three dependent
//   reads, one per stage: map entry, tile pixel byte, palette color. Video memory has
//   one write and two read ports, so writes and renders go through at the same rate.
//   Reset clears the configuration registers and empties the pipeline. Neither
//   memory is cleared; an entry reads as undefined until it is written.
//   When the receiver stalls, each stage holds only while the stage after it is full,
//   so bubbles close up and s_ready drops only when all three stages are full. The user
//   writes configuration via the APB-style port only while idle; it is not enforced.
module tiled_background_pixel_renderer #(
    parameter int VRAM_HALFWORDS    = tbr_pkg::VRAM_HALFWORDS_DEF,
    parameter int SCREEN_TILES_WIDE = tbr_pkg::SCREEN_TILES_WIDE_DEF,
    parameter int SCREEN_TILES_HIGH = tbr_pkg::SCREEN_TILES_HIGH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  tbr_pkg::in_word_t            s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output tbr_pkg::out_word_t           m_data,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tbr_pkg::PADDR_W-1:0]  paddr,
    input  logic [tbr_pkg::PDATA_W-1:0]  pwdata,
    output logic [tbr_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import tbr_pkg::*;

    localparam int          VADDR_W = $clog2(VRAM_HALFWORDS);
    localparam logic [VIDX_W-1:0] VDEPTH  = VIDX_W'(VRAM_HALFWORDS);
    localparam logic [8:0]  X_LIMIT = 9'(8 * SCREEN_TILES_WIDE);
    localparam logic [8:0]  Y_LIMIT = 9'(8 * SCREEN_TILES_HIGH);

    // Fold an index below twice the depth back into the memory.
    function automatic logic [VIDX_W-1:0] wrap_idx(input logic [VIDX_W-1:0] idx);
        logic [VIDX_W-1:0] res;
        res = (idx >= VDEPTH) ? idx - VDEPTH : idx;
        return res;
    endfunction

    cfg_t cfg;

    // Pipeline stage registers.
    logic     v1_reg, v2_reg, v3_reg;
    logic     v1_next, v2_next, v3_next;
    in_word_t s1_word_reg;
    in_word_t s2_word_reg;
    logic [3:0] s2_bank_reg;
    logic [7:0] s3_x_reg;
    logic [7:0] s3_y_reg;

    logic en1, en2, en3;
    logic acc;
    logic on_screen;
    logic keep_word;

    // Memory port signals.
    logic                 vram_we;
    logic [VIDX_W-1:0]    vram_widx;
    logic [VIDX_W-1:0]    map_idx;
    logic [VIDX_W-1:0]    pix_idx;
    logic [15:0]          map_entry;
    logic [15:0]          pix_half;
    logic [7:0]           pix_byte;
    logic [3:0]           pix_nib;
    logic                 s1_render;
    logic                 s2_render;
    logic                 s2_palwr;
    logic                 pal_we;
    logic                 pal_re;
    logic [COLOR_W-1:0]   color;

    tbr_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Each stage advances when it is empty or the stage after it advances.
    assign en3     = !v3_reg || m_ready;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign acc     = s_valid && s_ready;

    // Stage 0: decode the incoming word; video writes retire here.
    assign on_screen = ({1'b0, s_data.pixel_x} < X_LIMIT) && ({1'b0, s_data.pixel_y} < Y_LIMIT);

    always_comb begin
        vram_we   = 1'b0;
        keep_word = 1'b0;
        case (s_data.action)
            ACT_VRAM_WRITE: vram_we   = acc;
            ACT_PAL_WRITE:  keep_word = 1'b1;
            ACT_RENDER:     keep_word = on_screen;
            default: ;
        endcase
    end

    assign vram_widx = wrap_idx({1'b0, s_data.address});
    assign map_idx   = wrap_idx({2'b00, cfg.map_base, s_data.pixel_y[7:3], s_data.pixel_x[7:3]});

    // Stage 1: map entry is in; form the tile pixel halfword index.
    assign s1_render = s1_word_reg.action == ACT_RENDER;
    assign pix_idx   = wrap_idx(({2'b00, cfg.char_base, 13'd0})
                              + {3'b000, map_entry[9:0], 4'd0}
                              + {13'd0, s1_word_reg.pixel_y[2:0], 1'b0}
                              + {16'd0, s1_word_reg.pixel_x[2]});

    // Stage 2: pick the byte and nibble, then read or write the palette.
    assign s2_render = s2_word_reg.action == ACT_RENDER;
    assign s2_palwr  = s2_word_reg.action == ACT_PAL_WRITE;
    assign pix_byte  = s2_word_reg.pixel_x[1] ? pix_half[15:8] : pix_half[7:0];
    assign pix_nib   = s2_word_reg.pixel_x[0] ? pix_byte[7:4] : pix_byte[3:0];
    assign pal_we    = en3 && v2_reg && s2_palwr;
    assign pal_re    = en3 && v2_reg && s2_render;

    tbr_vram #(
        .DEPTH (VRAM_HALFWORDS)
    ) u_vram (
        .aclk    (aclk),
        .we      (vram_we),
        .waddr   (vram_widx[VADDR_W-1:0]),
        .wdata   (s_data.write_data),
        .re_a    (acc),
        .raddr_a (map_idx[VADDR_W-1:0]),
        .rdata_a (map_entry),
        .re_b    (en2 && v1_reg),
        .raddr_b (pix_idx[VADDR_W-1:0]),
        .rdata_b (pix_half)
    );

    tbr_palette u_palette (
        .aclk  (aclk),
        .we    (pal_we),
        .waddr (s2_word_reg.address[PAL_ADDR_W-1:0]),
        .wdata (s2_word_reg.write_data[COLOR_W-1:0]),
        .re    (pal_re),
        .raddr ({s2_bank_reg, pix_nib}),
        .rdata (color)
    );

    // Valid bits for the three stages.
    always_comb begin
        v1_next = v1_reg;
        v2_next = v2_reg;
        v3_next = v3_reg;
        if (en1) v1_next = acc && keep_word;
        if (en2) v2_next = v1_reg;
        if (en3) v3_next = v2_reg && s2_render;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_word_reg <= s_data;
        end
        if (en2 && v1_reg) begin
            s2_word_reg <= s1_word_reg;
            s2_bank_reg <= s1_render ? map_entry[15:12] : 4'd0;
        end
        if (pal_re) begin
            s3_x_reg <= s2_word_reg.pixel_x;
            s3_y_reg <= s2_word_reg.pixel_y;
        end
    end

    // Expand each five-bit channel to eight bits.
    assign m_valid      = v3_reg;
    assign m_data.red   = {color[4:0], 3'b000};
    assign m_data.green = {color[9:5], 3'b000};
    assign m_data.blue  = {color[14:10], 3'b000};
    assign m_data.out_x = s3_x_reg;
    assign m_data.out_y = s3_y_reg;

endmodule

>>> rtl/tbr_checker.sv
// Port-level checks for the tiled background pixel renderer, bound to the top level.
// Depends on tbr_pkg for the word types.
module tbr_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input tbr_pkg::out_word_t m_data
);
    import tbr_pkg::*;

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // An offered input word stays offered until it is taken.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input word withdrawn before it was accepted");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word present after reset");

    // Input backpressure only comes from a stalled, waiting result.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

    // Expanded channels keep their three low bits clear.
    a_expand: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.red[2:0] == 3'd0 && m_data.green[2:0] == 3'd0
                    && m_data.blue[2:0] == 3'd0)
        else $error("color channel not expanded from five bits");

endmodule

bind tiled_background_pixel_renderer tbr_checker u_tbr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
